// ===== src/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_INVALID  = 3'd1;
    localparam logic [2:0] ERR_TRAIL    = 3'd2;
    localparam logic [2:0] ERR_OVERLONG = 3'd3;
    localparam logic [2:0] ERR_EARLY    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] scalar;
        logic [2:0]      error;
        logic            at_end;
    } result_t;

    typedef struct packed {
        logic [CP_W-1:0] accumulator;
        logic [2:0]      seq_length;
        logic [2:0]      bytes_held;
        logic            trail_bad;
        logic            error_lock;
    } dec_state_t;

endpackage

// ===== src/utf8d_step.sv =====
module utf8d_step (
    input  utf8d_pkg::dec_state_t state,
    input  utf8d_pkg::item_t      item,
    output utf8d_pkg::dec_state_t state_next,
    output logic                  result_valid,
    output utf8d_pkg::result_t    result
);
    import utf8d_pkg::*;

    function automatic logic [2:0] judge(input logic [CP_W-1:0] cp, input logic [2:0] len,
                                         input logic bad);
        logic [2:0] need;
        begin
            if (cp < 21'h80)
                need = 3'd1;
            else if (cp < 21'h800)
                need = 3'd2;
            else if (cp < 21'h10000)
                need = 3'd3;
            else
                need = 3'd4;
            if (bad)
                judge = ERR_TRAIL;
            else if (need != len)
                judge = ERR_OVERLONG;
            else if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
                judge = ERR_INVALID;
            else
                judge = ERR_NONE;
        end
    endfunction

    logic [7:0]      b;
    logic            last;
    logic [2:0]      lead_len;
    logic [CP_W-1:0] lead_bits;
    logic [CP_W-1:0] acc_grow;
    logic [2:0]      held_grow;
    logic            bad_grow;
    logic            done;
    logic [2:0]      err;
    logic [CP_W-1:0] cp;

    assign b         = item.in_byte;
    assign last      = item.string_end;
    assign acc_grow  = {state.accumulator[CP_W-7:0], b[5:0]};
    assign held_grow = state.bytes_held + 3'd1;
    assign bad_grow  = state.trail_bad | (b[7:6] != 2'b10);

    // lead byte class
    always_comb
    begin
        priority if (b[7] == 1'b0)
        begin
            lead_len  = 3'd1;
            lead_bits = {{(CP_W-7){1'b0}}, b[6:0]};
        end
        else if (b[7:5] == 3'b110)
        begin
            lead_len  = 3'd2;
            lead_bits = {{(CP_W-5){1'b0}}, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            lead_len  = 3'd3;
            lead_bits = {{(CP_W-4){1'b0}}, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            lead_len  = 3'd4;
            lead_bits = {{(CP_W-3){1'b0}}, b[2:0]};
        end
        else
        begin
            lead_len  = 3'd0;
            lead_bits = '0;
        end
    end

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        err        = ERR_NONE;
        cp         = '0;

        if (state.error_lock)
        begin
            if (last)
                state_next = '0;
        end
        else if (state.bytes_held == 3'd0)
        begin
            priority if (lead_len == 3'd0)
            begin
                done = 1'b1;
                err  = ERR_INVALID;
            end
            else if (lead_len == 3'd1)
            begin
                done = 1'b1;
                cp   = lead_bits;
            end
            else if (last)
            begin
                done = 1'b1;
                err  = ERR_EARLY;
            end
            else
            begin
                state_next.accumulator = lead_bits;
                state_next.seq_length  = lead_len;
                state_next.bytes_held  = 3'd1;
                state_next.trail_bad   = 1'b0;
            end
        end
        else
        begin
            priority if (held_grow >= state.seq_length)
            begin
                done = 1'b1;
                err  = judge(acc_grow, state.seq_length, bad_grow);
                cp   = acc_grow;
            end
            else if (last)
            begin
                done = 1'b1;
                err  = ERR_EARLY;
            end
            else
            begin
                state_next.accumulator = acc_grow;
                state_next.bytes_held  = held_grow;
                state_next.trail_bad   = bad_grow;
            end
        end

        if (done)
        begin
            state_next.accumulator = '0;
            state_next.seq_length  = '0;
            state_next.bytes_held  = '0;
            state_next.trail_bad   = 1'b0;
            if (err != ERR_NONE)
            begin
                cp = '0;
                state_next.error_lock = !last;
            end
        end

        result_valid  = done;
        result.scalar = cp;
        result.error  = err;
        result.at_end = last;
    end

endmodule

// ===== src/utf8_stream_decoder.sv =====
// utf8_stream_decoder: streaming utf-8 to code point decoder
//
// item channel: one byte per transfer with string_end marking the final byte
// of a string. result channel: one code point, error code and at_end flag per
// transfer. bytes that only extend a sequence, and bytes dropped after an
// error up to the end of the string, give no result.
//
// a byte is taken into the input register, and its result, if any, then moves
// from the decode step into the output register.
// throughput: one byte per cycle while the output is not stalled, set by the
// combinational decode step between the input register and the output register.
//
// reset clears the valid flags of both registers, the collection state and the error lock.
// while the output register holds a result and result_stall is high, the byte
// in the input register waits and item_stall rises if that register is full;
// nothing is lost or repeated.
module utf8_stream_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  utf8d_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output utf8d_pkg::result_t result
);
    import utf8d_pkg::*;

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_item_reg;
    dec_state_t state_reg, state_next;

    dec_state_t step_state;
    logic       step_valid;
    result_t    step_result;
    logic       out_free;
    logic       advance;
    logic       take;

    utf8d_step u_step (
        .state        (state_reg),
        .item         (in_item_reg),
        .state_next   (step_state),
        .result_valid (step_valid),
        .result       (step_result)
    );

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        state_next = advance ? step_state : state_reg;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step_valid;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= item;
        if (advance && step_valid)
            out_item_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
